// ----- hw/rtl/rts_pkg.sv -----
`default_nettype none

package rts_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int OCC_W       = 5;

  localparam logic [2:0] POL_FCFS     = 3'd0;
  localparam logic [2:0] POL_SJF      = 3'd1;
  localparam logic [2:0] POL_SRTF     = 3'd2;
  localparam logic [2:0] POL_PRIO_PRE = 3'd3;
  localparam logic [2:0] POL_PRIO_NP  = 3'd4;
  localparam logic [2:0] POL_RR       = 3'd5;

  localparam logic MODE_ADMIT  = 1'b0;
  localparam logic MODE_SELECT = 1'b1;

  typedef enum logic [1:0] {
    ST_ADMITTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_SELECTED = 2'd2,
    ST_NONE     = 2'd3
  } status_t;

  typedef struct packed {
    logic        mode;
    logic [15:0] task_id;
    logic [15:0] burst_ticks;
    logic [15:0] remaining_ticks;
    logic [7:0]  prio_level;
    logic        running_valid;
    logic [15:0] running_left;
  } in_item_t;

  typedef struct packed {
    status_t          status;
    logic [15:0]      chosen_id;
    logic [15:0]      chosen_remaining;
    logic [OCC_W-1:0] occupancy;
  } out_item_t;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] burst;
    logic [15:0] remaining;
    logic [7:0]  prio;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

endpackage

`default_nettype wire

// ----- hw/rtl/rts_table.sv -----
`default_nettype none

module rts_table (
  input  wire logic              clk,
  input  wire rts_pkg::mem_req_t req,
  output rts_pkg::entry_t        rd_data
);

  rts_pkg::entry_t mem [rts_pkg::TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_data <= mem[req.raddr];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/rts_ctrl.sv -----
`default_nettype none

module rts_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire rts_pkg::in_item_t  in_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_data,
  output logic                    res_valid,
  output rts_pkg::out_item_t      res,
  input  wire logic               res_take,
  output rts_pkg::mem_req_t       mem_req,
  input  wire rts_pkg::entry_t    rd_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_COMPACT,
    S_DONE
  } state_t;

  state_t                      state;
  logic [rts_pkg::CNT_W-1:0]   count;
  logic [2:0]                  policy;
  logic [rts_pkg::CNT_W-1:0]   ptr;
  logic                        dvld;
  logic [rts_pkg::IDX_W-1:0]   didx;
  logic [rts_pkg::IDX_W-1:0]   best_idx;
  logic [15:0]                 best_key;
  logic [15:0]                 best_id;
  logic [15:0]                 best_rem;
  logic                        run_valid;
  logic [15:0]                 run_left;

  logic [15:0]                 key;
  logic [15:0]                 cmp_a;
  logic [15:0]                 cmp_b;
  logic                        lt;
  logic                        issue;
  logic                        full;
  logic [rts_pkg::CNT_W-1:0]   count_dec;
  logic [rts_pkg::CNT_W-1:0]   after_best;

  always_comb begin
    case (policy)
      rts_pkg::POL_SJF:      key = rd_data.burst;
      rts_pkg::POL_SRTF:     key = rd_data.remaining;
      rts_pkg::POL_PRIO_PRE,
      rts_pkg::POL_PRIO_NP:  key = {8'd0, rd_data.prio};
      default:               key = '0;
    endcase
  end

  // One comparator: entry key vs best during the scan, running task vs best after it.
  always_comb begin
    if (state == S_DECIDE) begin
      cmp_a = run_left;
      cmp_b = best_rem;
    end else begin
      cmp_a = key;
      cmp_b = best_key;
    end
  end

  assign lt         = cmp_a < cmp_b;
  assign issue      = ptr < count;
  assign full       = count >= rts_pkg::CNT_W'(rts_pkg::TABLE_DEPTH);
  assign count_dec  = count - 1'b1;
  assign after_best = rts_pkg::CNT_W'(best_idx) + 1'b1;

  assign in_stall  = state != S_IDLE;
  assign cfg_ready = 1'b1;
  assign res_valid = state == S_DONE;

  always_comb begin
    mem_req.raddr = ptr[rts_pkg::IDX_W-1:0];
    mem_req.we    = 1'b0;
    mem_req.waddr = count[rts_pkg::IDX_W-1:0];
    mem_req.wdata = '{id:        in_data.task_id,
                      burst:     in_data.burst_ticks,
                      remaining: in_data.remaining_ticks,
                      prio:      in_data.prio_level};
    if (state == S_IDLE) begin
      mem_req.we = in_valid && (in_data.mode == rts_pkg::MODE_ADMIT) && !full;
    end else if (state == S_COMPACT) begin
      // shift the younger entry down by one
      mem_req.we    = dvld;
      mem_req.waddr = didx - 1'b1;
      mem_req.wdata = rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      policy <= rts_pkg::POL_FCFS;
      dvld   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        policy <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            run_valid <= in_data.running_valid;
            run_left  <= in_data.running_left;
            ptr       <= '0;
            dvld      <= 1'b0;
            res.chosen_id        <= '0;
            res.chosen_remaining <= '0;
            if (in_data.mode == rts_pkg::MODE_ADMIT) begin
              state <= S_DONE;
              if (full) begin
                res.status    <= rts_pkg::ST_FULL;
                res.occupancy <= rts_pkg::OCC_W'(count);
              end else begin
                count         <= count + 1'b1;
                res.status    <= rts_pkg::ST_ADMITTED;
                res.occupancy <= rts_pkg::OCC_W'(count + 1'b1);
              end
            end else if (count == '0) begin
              res.status    <= rts_pkg::ST_NONE;
              res.occupancy <= '0;
              state         <= S_DONE;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (issue) begin
            ptr  <= ptr + 1'b1;
            dvld <= 1'b1;
            didx <= ptr[rts_pkg::IDX_W-1:0];
          end else begin
            dvld <= 1'b0;
          end
          if (dvld && (didx == '0 || lt)) begin
            best_idx <= didx;
            best_key <= key;
            best_id  <= rd_data.id;
            best_rem <= rd_data.remaining;
          end
          if (dvld && !issue) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (policy == rts_pkg::POL_SRTF && run_valid && lt) begin
            // keep the running task
            res.status    <= rts_pkg::ST_NONE;
            res.occupancy <= rts_pkg::OCC_W'(count);
            state         <= S_DONE;
          end else begin
            res.status           <= rts_pkg::ST_SELECTED;
            res.chosen_id        <= best_id;
            res.chosen_remaining <= best_rem;
            res.occupancy        <= rts_pkg::OCC_W'(count_dec);
            ptr                  <= after_best;
            if (after_best >= count) begin
              count <= count_dec;
              state <= S_DONE;
            end else begin
              state <= S_COMPACT;
            end
          end
        end
        S_COMPACT: begin
          if (issue) begin
            ptr  <= ptr + 1'b1;
            dvld <= 1'b1;
            didx <= ptr[rts_pkg::IDX_W-1:0];
          end else begin
            dvld <= 1'b0;
          end
          if (dvld && !issue) begin
            count <= count_dec;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ready_table_scheduler_select.sv -----
// Admit, and select on an empty table: the controller goes straight from idle to done, with no scan.
// Select: a scan over the N entries held (N = entries held), then a decide step, plus a compaction pass
//   when entry k is removed and the younger entries shift down.
// One item in flight; the next item is accepted the cycle after the result moves to
//   the output register.
// Sync reset empties the table, sets policy to FCFS and drops any pending item.
`default_nettype none

module ready_table_scheduler_select (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire rts_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output rts_pkg::out_item_t      out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_data
);

  logic                res_valid;
  rts_pkg::out_item_t  res;
  logic                res_take;
  logic                slot_free;
  rts_pkg::mem_req_t   mem_req;
  rts_pkg::entry_t     rd_data;

  rts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take),
    .mem_req   (mem_req),
    .rd_data   (rd_data)
  );

  rts_table u_table (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  assign slot_free = !out_valid || !out_stall;
  assign res_take  = res_valid && slot_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (slot_free) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_data <= res;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/rts_checker.sv -----
`default_nettype none

module rts_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire rts_pkg::out_item_t out_data
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != rts_pkg::ST_SELECTED |->
      out_data.chosen_id == '0 && out_data.chosen_remaining == '0)
    else $error("chosen fields nonzero without a selection");

  a_full_occ: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == rts_pkg::ST_FULL |->
      out_data.occupancy == rts_pkg::OCC_W'(rts_pkg::TABLE_DEPTH))
    else $error("full reported below capacity");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while busy");

endmodule

bind ready_table_scheduler_select rts_checker u_rts_checker (.*);

`default_nettype wire
